>>> rtl/bqc_pkg.sv
// Shared constants and codes for the biquad cascade filter.
package bqc_pkg;

    localparam int MAX_STAGES = 4;
    localparam int STAGE_W    = $clog2(MAX_STAGES);
    localparam int NUM_TAPS   = 5;
    localparam int TAP_W      = 3;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int PROD_SHIFT = 16;
    localparam int MAC_W      = COEF_W + SAMPLE_W - PROD_SHIFT;
    localparam int ERR_W      = 14;
    localparam int ACC_W      = 34;

    localparam int ACTIVE_W   = 3;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_ACTIVE_STAGES = 1'b0;

    // Input stream packing.
    localparam int S_TDATA_W  = 56;
    localparam int SAMPLE_LSB = 0;
    localparam int STAGE_LSB  = SAMPLE_LSB + SAMPLE_W;
    localparam int TAP_LSB    = STAGE_LSB + 2;
    localparam int COEF_LSB   = TAP_LSB + TAP_W;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

endpackage

>>> rtl/bqc_mac.sv
// Shared coefficient-by-sample multiplier with registered, floored Q16 scaling.
module bqc_mac (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [bqc_pkg::COEF_W-1:0]    coef,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0]  operand,
    output logic signed [bqc_pkg::MAC_W-1:0]     prod
);
    import bqc_pkg::*;

    logic signed [COEF_W+SAMPLE_W-1:0] full_prod;
    logic signed [MAC_W-1:0]           prod_reg;

    assign full_prod = coef * operand;

    // Dropping the low bits of a two's complement product is a floor shift.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full_prod[COEF_W+SAMPLE_W-1:PROD_SHIFT];
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/biquad_cascade_filter.sv
// Top level of the biquad cascade filter: stream ports, register port, sequencer and state.
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_tvalid / s_tready   s_tuser = cmd, s_tdata = sample, stage, tap, coef
//  m_        out        m_tvalid / m_tready   m_tdata = filtered sample
//  APB       in         psel/penable/pready   register 0 at byte address 0: active_stages
//
// A filter transaction passes each active stage in turn: a multiply phase in which the single
// shared multiplier forms one product per tap, and a finishing step that adds the last
// product, saturates and updates the stage history. A new sample is accepted only once the
// sample before it has left the sequencer, so samples do not overlap. A coefficient load
// completes in the accepting cycle. The synchronous reset clears every coefficient, the
// histories and the shaping errors, and sets active_stages to one. A result that waits on
// m_tready does not block acceptance, but the last stage of the next sample holds in its
// final cycle until the output register is free.
module biquad_cascade_filter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bqc_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [bqc_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_in [15:0], stage_sel [17:16], tap_sel [20:18], coef_value [52:21], zero [55:53]
    input  logic [bqc_pkg::S_TDATA_W-1:0]        s_tdata,
    // cmd [0]
    input  logic                                 s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample_out [15:0]
    output logic [bqc_pkg::SAMPLE_W-1:0]         m_tdata
);
    import bqc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Sequencer state.
    logic [1:0]          state_reg, state_next;
    logic [STAGE_W-1:0]  stage_reg, stage_next;
    logic [STAGE_W-1:0]  last_stage_reg, last_stage_next;
    logic [TAP_W-1:0]    tap_reg, tap_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ACTIVE_W-1:0] active_reg;

    // Datapath registers.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [SAMPLE_W-1:0]        out_reg;

    // Filter state.
    logic signed [COEF_W-1:0]   coef_reg [MAX_STAGES][NUM_TAPS];
    logic signed [SAMPLE_W-1:0] xh_reg   [MAX_STAGES][2];
    logic signed [SAMPLE_W-1:0] yh_reg   [MAX_STAGES][2];
    logic [ERR_W-1:0]           err_reg  [MAX_STAGES];

    // Unpacked input fields.
    logic                       in_cmd;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [STAGE_W-1:0]         in_stage;
    logic [TAP_W-1:0]           in_tap;
    logic signed [COEF_W-1:0]   in_coef;
    logic signed [COEF_W-1:0]   load_value;

    logic s_acc, load_go, filt_go, fin_go, last_stage;
    logic cfg_write;
    logic [ACTIVE_W-1:0] active_m1;

    // Multiplier operands and accumulation.
    logic signed [COEF_W-1:0]   mac_coef;
    logic signed [SAMPLE_W-1:0] mac_operand;
    logic signed [MAC_W-1:0]    mac_prod;
    logic signed [ACC_W-1:0]    total;
    logic                       total_ovf;
    logic signed [SAMPLE_W-1:0] stage_out;

    assign in_cmd    = s_tuser;
    assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];
    assign in_stage  = s_tdata[STAGE_LSB +: STAGE_W];
    assign in_tap    = s_tdata[TAP_LSB +: TAP_W];
    assign in_coef   = s_tdata[COEF_LSB +: COEF_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign filt_go  = s_acc && (in_cmd == CMD_FILTER);

    // Loads to a stage beyond the cascade or to an unknown tap are dropped.
    assign load_go  = s_acc && (in_cmd == CMD_LOAD) && (int'(in_stage) < MAX_STAGES)
                      && (in_tap <= TAP_A2);

    // Feedback taps are kept negated so that every product is summed.
    assign load_value = (in_tap >= TAP_A1) ? (COEF_W'(0) - in_coef) : in_coef;

    assign last_stage = (stage_reg == last_stage_reg);

    // The final cycle of the last stage waits for the output register to drain.
    assign fin_go = (state_reg == ST_FIN) && (!last_stage || !m_tvalid_reg || m_tready);

    // Configuration register: any byte address within the first word selects it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CFG_ADDR_W-1] == REG_ACTIVE_STAGES);
    assign prdata    = (paddr[CFG_ADDR_W-1] == REG_ACTIVE_STAGES)
                       ? CFG_DATA_W'(active_reg) : '0;

    // A stage count of zero behaves as one, and one above the cascade depth saturates.
    assign active_m1 = active_reg - ACTIVE_W'(1);
    always_comb begin
        if (active_reg == '0) begin
            last_stage_next = '0;
        end else if (int'(active_reg) > MAX_STAGES) begin
            last_stage_next = STAGE_W'(MAX_STAGES - 1);
        end else begin
            last_stage_next = active_m1[STAGE_W-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_coef = coef_reg[stage_reg][tap_reg];
        case (tap_reg)
            TAP_B0:  mac_operand = x_reg;
            TAP_B1:  mac_operand = xh_reg[stage_reg][0];
            TAP_B2:  mac_operand = xh_reg[stage_reg][1];
            TAP_A1:  mac_operand = yh_reg[stage_reg][0];
            default: mac_operand = yh_reg[stage_reg][1];
        endcase
    end

    bqc_mac u_mac (
        .aclk    (aclk),
        .en      (state_reg == ST_MAC),
        .coef    (mac_coef),
        .operand (mac_operand),
        .prod    (mac_prod)
    );

    // Final sum, then floor shift by the error width and saturation to 16 bits.
    assign total     = acc_reg + ACC_W'(mac_prod);
    assign total_ovf = !((&total[ACC_W-1:ERR_W+SAMPLE_W-1]) ||
                         !(|total[ACC_W-1:ERR_W+SAMPLE_W-1]));
    assign stage_out = total_ovf ? (total[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                 : total[ERR_W +: SAMPLE_W];

    // Sequencer: a multiply state that steps through the five taps of each stage, then a finishing state.
    always_comb begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        tap_next      = tap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (filt_go) begin
                    state_next = ST_MAC;
                    stage_next = '0;
                    tap_next   = TAP_B0;
                end
            end
            ST_MAC: begin
                if (tap_reg == TAP_A2) begin
                    state_next = ST_FIN;
                end else begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    tap_next = TAP_B0;
                    if (last_stage) begin
                        state_next    = ST_IDLE;
                        m_tvalid_next = 1'b1;
                    end else begin
                        state_next = ST_MAC;
                        stage_next = stage_reg + STAGE_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stage_reg      <= '0;
            last_stage_reg <= '0;
            tap_reg        <= TAP_B0;
            m_tvalid_reg   <= 1'b0;
            active_reg     <= ACTIVE_RESET;
        end else begin
            state_reg    <= state_next;
            stage_reg    <= stage_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
            if (filt_go) begin
                last_stage_reg <= last_stage_next;
            end
            if (cfg_write) begin
                active_reg <= pwdata[ACTIVE_W-1:0];
            end
        end
    end

    // Datapath: the accumulator starts from the carried error of the stage.
    always_ff @(posedge aclk) begin
        if (filt_go) begin
            x_reg <= in_sample;
        end else if (fin_go) begin
            x_reg <= stage_out;
        end
        if (state_reg == ST_MAC) begin
            if (tap_reg == TAP_B0) begin
                acc_reg <= ACC_W'(err_reg[stage_reg]);
            end else begin
                acc_reg <= total;
            end
        end
        if (fin_go && last_stage) begin
            out_reg <= stage_out;
        end
    end

    // Coefficients, histories and errors; a load clears the history of its stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                for (int t = 0; t < NUM_TAPS; t++) begin
                    coef_reg[s][t] <= '0;
                end
                xh_reg[s][0] <= '0;
                xh_reg[s][1] <= '0;
                yh_reg[s][0] <= '0;
                yh_reg[s][1] <= '0;
                err_reg[s]   <= '0;
            end
        end else if (load_go) begin
            coef_reg[in_stage][in_tap] <= load_value;
            xh_reg[in_stage][0]        <= '0;
            xh_reg[in_stage][1]        <= '0;
            yh_reg[in_stage][0]        <= '0;
            yh_reg[in_stage][1]        <= '0;
            err_reg[in_stage]          <= '0;
        end else if (fin_go) begin
            xh_reg[stage_reg][1] <= xh_reg[stage_reg][0];
            xh_reg[stage_reg][0] <= x_reg;
            yh_reg[stage_reg][1] <= yh_reg[stage_reg][0];
            yh_reg[stage_reg][0] <= stage_out;
            err_reg[stage_reg]   <= total[ERR_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_reg <= TAP_A2)
        else $error("tap counter left the tap range");

    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (stage_reg <= last_stage_reg))
        else $error("stage counter passed the last active stage");

    a_mac_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC && tap_reg == TAP_A2) |=> (state_reg == ST_FIN))
        else $error("last product was not followed by the finishing cycle");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_FIN
                                 && $past(stage_reg) == $past(last_stage_reg)))
        else $error("result raised outside the finish of the last stage");

    a_load_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_cmd == CMD_LOAD) |=> (state_reg == ST_IDLE))
        else $error("coefficient load started a filter pass");
`endif

endmodule
